FILE: sv/bcrp_pkg.sv
// Shared constants and types for the bigram count and roulette pick unit.
package bcrp_pkg;

  localparam int VOCAB_SIZE  = 256;
  localparam int WORD_W      = $clog2(VOCAB_SIZE);
  localparam int WC_W        = WORD_W + 1;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 24;
  localparam int RAND_W      = 31;
  localparam int PAIR_AW     = 2 * WORD_W;

  localparam logic [WORD_W-1:0] START_SYM = WORD_W'(0);
  localparam logic [WORD_W-1:0] END_SYM   = WORD_W'(1);

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_LAST  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic MODE_LEARN = 1'b0;

  typedef logic [SUM_W-1:0] sum_t;

endpackage

FILE: sv/bcrp_div.sv
// Bit-serial restoring divider that returns the remainder, one quotient bit per cycle.
module bcrp_div
  import bcrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [RAND_W-1:0] dividend,
  input  sum_t              divisor,
  output logic              done,
  output sum_t              remainder
);

  localparam int CNT_W = $clog2(RAND_W + 1);

  logic [RAND_W-1:0] shreg;
  sum_t              dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [SUM_W:0]    trial;

  assign trial = {remainder, shreg[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(RAND_W);
        shreg     <= dividend;
        dvs       <= divisor;
        remainder <= '0;
      end else if (busy) begin
        shreg <= shreg << 1;
        if (trial >= {1'b0, dvs}) begin
          remainder <= SUM_W'(trial - {1'b0, dvs});
        end else begin
          remainder <= trial[SUM_W-1:0];
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/bigram_count_and_roulette_pick_unit.sv
// Top level: bigram count memory, row sums, learn/pick sequencer and result register.
//
// After reset the block sweeps the count memory clear, one entry a cycle, and takes no
// item until then. A learn item reads and then writes the count memory, and does so twice
// when it is the last word of a sentence, which bumps two counts. A pick on a row with a
// nonzero sum takes the two remainders from the shared bit-serial divider (start column,
// then the draw limit), one after the other, then walks the columns through the count
// memory's single read port, reading each column and then adding its count. One item is
// in work at a time; the result sits in an output register while the next item is taken.
module bigram_count_and_roulette_pick_unit
  import bcrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // position[1:0], word_index[9:2], random_value[40:10]
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // next_word[7:0], status[9:8], words_in_use[18:10]
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_L_RD   = 4'd2;
  localparam logic [3:0] S_L_WR   = 4'd3;
  localparam logic [3:0] S_P_RD   = 4'd4;
  localparam logic [3:0] S_P_SUM  = 4'd5;
  localparam logic [3:0] S_P_DIV1 = 4'd6;
  localparam logic [3:0] S_P_DIV2 = 4'd7;
  localparam logic [3:0] S_W_RD   = 4'd8;
  localparam logic [3:0] S_W_ACC  = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0]          state;
  logic [PAIR_AW-1:0]  clr_addr;
  logic [WORD_W-1:0]   prev_word;
  logic [WC_W-1:0]     wc;
  logic [WORD_W-1:0]   cur_word;
  logic [RAND_W-1:0]   rnd;
  logic                last_pass;   // second count bump of a last-word learn pending
  logic                sum_pend;
  logic [WORD_W-1:0]   cnt_row;
  logic [WORD_W-1:0]   cnt_col;
  logic [WORD_W-1:0]   sum_row;
  logic [COUNT_W-1:0]  cnt_q;
  sum_t                sum_q;
  sum_t                total;
  logic [SUM_W:0]      lim;
  logic [SUM_W:0]      run;
  logic [SUM_W:0]      run_next;
  logic [WC_W-1:0]     steps;
  logic [WORD_W-1:0]   res_word;
  logic [1:0]          res_status;

  logic [COUNT_W-1:0]  pair_counts [2**PAIR_AW];
  sum_t                row_sums    [VOCAB_SIZE];

  logic                div_go;
  logic [RAND_W-1:0]   div_a;
  sum_t                div_b;
  logic                div_done;
  sum_t                div_rem;

  logic [WORD_W-1:0]   in_word;
  logic [1:0]          in_pos;

  assign in_pos   = s_tdata[1:0];
  assign in_word  = s_tdata[9:2];
  assign s_tready = (state == S_IDLE);
  assign run_next = run + (SUM_W+1)'(cnt_q);

  always_comb begin
    div_go = ((state == S_P_SUM) && (sum_q != '0)) || ((state == S_P_DIV1) && div_done);
    if (state == S_P_SUM) begin
      div_a = RAND_W'(cur_word) + RAND_W'(1);
      div_b = SUM_W'(wc);
    end else begin
      div_a = rnd;
      div_b = total;
    end
  end

  bcrp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Memories: registered reads from the address registers every cycle.
  always_ff @(posedge clk) begin
    cnt_q <= pair_counts[{cnt_row, cnt_col}];
    sum_q <= row_sums[sum_row];
    if (state == S_CLEAR) begin
      pair_counts[clr_addr] <= '0;
      if (clr_addr[PAIR_AW-1:WORD_W] == '0) begin
        row_sums[clr_addr[WORD_W-1:0]] <= '0;
      end
    end else if (state == S_L_WR) begin
      if (cnt_q != '1) begin
        pair_counts[{cnt_row, cnt_col}] <= cnt_q + COUNT_W'(1);
      end
      if (sum_pend && (sum_q != '1)) begin
        row_sums[sum_row] <= sum_q + SUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      prev_word <= START_SYM;
      wc        <= WC_W'(2);
      m_tvalid  <= 1'b0;
    end else begin
      // in S_FINISH the result register is reloaded below
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PAIR_AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cur_word   <= in_word;
            rnd        <= s_tdata[40:10];
            res_word   <= in_word;
            res_status <= ST_OK;
            sum_pend   <= 1'b1;
            last_pass  <= (s_tuser == MODE_LEARN) && (in_pos == POS_LAST);
            if (s_tuser == MODE_LEARN) begin
              if ({1'b0, in_word} >= wc) begin
                wc <= {1'b0, in_word} + WC_W'(1);
              end
              priority if (in_pos == POS_FIRST) begin
                cnt_row <= START_SYM;
                cnt_col <= in_word;
                sum_row <= START_SYM;
              end else if (in_pos == POS_LAST) begin
                cnt_row   <= in_word;
                cnt_col   <= END_SYM;
                sum_row   <= END_SYM;
              end else begin
                cnt_row <= prev_word;
                cnt_col <= in_word;
                sum_row <= prev_word;
              end
              state <= S_L_RD;
            end else begin
              sum_row <= in_word;
              state   <= S_P_RD;
            end
          end
        end
        S_L_RD: state <= S_L_WR;
        S_L_WR: begin
          sum_pend <= 1'b0;
          if (last_pass) begin
            last_pass <= 1'b0;
            cnt_row   <= END_SYM;
            cnt_col   <= cur_word;
            state     <= S_L_RD;
          end else begin
            prev_word <= cur_word;
            state     <= S_FINISH;
          end
        end
        S_P_RD: state <= S_P_SUM;
        S_P_SUM: begin
          total <= sum_q;
          if (sum_q == '0) begin
            res_status <= ST_EMPTY;
            state      <= S_FINISH;
          end else begin
            state <= S_P_DIV1;
          end
        end
        S_P_DIV1: begin
          if (div_done) begin
            cnt_col <= div_rem[WORD_W-1:0];
            state   <= S_P_DIV2;
          end
        end
        S_P_DIV2: begin
          if (div_done) begin
            lim     <= {1'b0, div_rem} + (SUM_W+1)'(1);
            run     <= '0;
            steps   <= wc - WC_W'(1);
            cnt_row <= cur_word;
            state   <= S_W_RD;
          end
        end
        S_W_RD: state <= S_W_ACC;
        S_W_ACC: begin
          run   <= run_next;
          steps <= steps - WC_W'(1);
          if (run_next >= lim) begin
            res_word <= cnt_col;
            state    <= S_FINISH;
          end else if (steps == WC_W'(1)) begin
            state <= S_FINISH;
          end else begin
            // wrap the column walk at the vocabulary size in use
            if (({1'b0, cnt_col} + WC_W'(1)) == wc) begin
              cnt_col <= '0;
            end else begin
              cnt_col <= cnt_col + WORD_W'(1);
            end
            state <= S_W_RD;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, wc, res_status, res_word};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/bigram_count_and_roulette_pick_unit_tb.sv
// Testbench for the bigram count and roulette pick unit: sentence learning, picks, checks.
module bigram_count_and_roulette_pick_unit_tb;
  import bcrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] POS_MIDDLE   = 2'd1;
  localparam logic [1:0] POS_RESERVED = 2'd3;
  localparam logic       MODE_PICK    = ~MODE_LEARN;
  localparam int         N_ITEMS      = 750;
  localparam int         QUIET_FROM   = 650;

  // Listed from the top bit down, so next_word lands in the low bits.
  typedef struct packed {
    logic [WC_W-1:0]   words_in_use;
    logic [1:0]        status;
    logic [WORD_W-1:0] next_word;
  } answer_t;

  class bigram_scoreboard;
    logic [COUNT_W-1:0] pair_cnt[VOCAB_SIZE][VOCAB_SIZE];
    sum_t               row_total[VOCAB_SIZE];
    logic [WORD_W-1:0]  prev_word;
    int unsigned        vocab_used;
    answer_t            pending[$];
    int                 errors;

    function new();
      foreach (pair_cnt[r, c]) pair_cnt[r][c] = '0;
      foreach (row_total[r]) row_total[r] = '0;
      prev_word  = START_SYM;
      vocab_used = 2;
      errors     = 0;
    endfunction

    function void bump(logic [WORD_W-1:0] r, logic [WORD_W-1:0] c);
      if (pair_cnt[r][c] != '1) pair_cnt[r][c]++;
    endfunction

    function void bump_total(logic [WORD_W-1:0] r);
      if (row_total[r] != '1) row_total[r]++;
    endfunction

    // Word index is 8 bits here, so vocabulary overflow cannot occur.
    function void note_item(logic mode, logic [1:0] pos, logic [WORD_W-1:0] w,
                            logic [RAND_W-1:0] rnd);
      answer_t a;
      longint unsigned lim, run;
      int unsigned c;
      a.next_word = w;
      a.status    = ST_OK;
      if (mode == MODE_LEARN) begin
        if (w >= vocab_used) vocab_used = w + 1;
        if (pos == POS_FIRST) begin
          bump(START_SYM, w);
          bump_total(START_SYM);
        end else if (pos == POS_LAST) begin
          bump(w, END_SYM);
          bump(END_SYM, w);
          bump_total(END_SYM);
        end else begin
          bump(prev_word, w);
          bump_total(prev_word);
        end
        prev_word = w;
      end else if (row_total[w] == 0) begin
        a.status = ST_EMPTY;
      end else begin
        lim = rnd % row_total[w] + 1;
        run = 0;
        for (int k = 1; k < vocab_used; k++) begin
          c = (w + k) % vocab_used;
          if (c != w) begin
            run += pair_cnt[w][c];
            if (run >= lim) begin
              a.next_word = WORD_W'(c);
              break;
            end
          end
        end
      end
      a.words_in_use = WC_W'(vocab_used);
      pending.push_back(a);
    endfunction

    function void check_result(logic [23:0] data);
      answer_t got, exp_a;
      got = data[18:0];
      if (pending.size() == 0) begin
        $error("result with no expectation: %h", data);
        errors++;
        return;
      end
      exp_a = pending.pop_front();
      if (got.next_word != exp_a.next_word) begin
        $error("next_word exp %0d got %0d", exp_a.next_word, got.next_word);
        errors++;
      end
      if (got.status != exp_a.status) begin
        $error("status exp %0d got %0d", exp_a.status, got.status);
        errors++;
      end
      if (got.words_in_use != exp_a.words_in_use) begin
        $error("words_in_use exp %0d got %0d", exp_a.words_in_use, got.words_in_use);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  bigram_scoreboard board = new();
  int  sent = 0;
  bit  quiet = 1'b0;

  bigram_count_and_roulette_pick_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_item(logic mode, logic [1:0] pos, logic [WORD_W-1:0] w,
                           logic [RAND_W-1:0] rnd);
    @(negedge clk);
    s_tuser  = mode;
    s_tdata  = {7'b0, rnd, w, pos};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_item(mode, pos, w, rnd);
    sent++;
    if (sent >= QUIET_FROM) quiet = 1'b1;
    // Random sender gap; when none, valid stays high into the next item.
    if (!quiet && $urandom_range(3) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(18)) @(negedge clk);
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(9) < 8) return WORD_W'($urandom_range(15));
    return WORD_W'($urandom_range(255));
  endfunction

  // Result side: sample at rising edge, drive ready at falling edge.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);

  initial begin
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(4) != 0) begin
        m_tready = 1'b1;
        if (!quiet) repeat ($urandom_range(30)) @(negedge clk);
      end else begin
        m_tready = 1'b0;
        repeat ($urandom_range(18)) @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] w;
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty row, each position, reserved position, extremes.
    send_item(MODE_PICK, POS_FIRST, 8'd5, 31'd0);
    send_item(MODE_LEARN, POS_FIRST, 8'd2, 31'd0);
    send_item(MODE_LEARN, POS_MIDDLE, 8'd3, '1);
    send_item(MODE_LEARN, POS_RESERVED, 8'd4, 31'd7);
    send_item(MODE_LEARN, POS_LAST, 8'd5, 31'd0);
    send_item(MODE_LEARN, POS_FIRST, 8'd3, 31'd0);
    send_item(MODE_LEARN, POS_MIDDLE, 8'd0, 31'd0);
    send_item(MODE_LEARN, POS_MIDDLE, 8'd1, 31'd0);
    send_item(MODE_LEARN, POS_LAST, 8'd2, 31'd0);
    send_item(MODE_PICK, POS_FIRST, 8'd0, 31'd0);
    send_item(MODE_PICK, POS_FIRST, 8'd0, '1);
    send_item(MODE_PICK, POS_RESERVED, 8'd1, 31'd1);
    send_item(MODE_PICK, POS_LAST, 8'd3, 31'd12345);
    send_item(MODE_PICK, POS_MIDDLE, 8'd2, '1);
    send_item(MODE_PICK, POS_FIRST, 8'd200, 31'd3);
    send_item(MODE_LEARN, POS_MIDDLE, 8'd255, '1);
    send_item(MODE_LEARN, POS_LAST, 8'd254, 31'd0);
    send_item(MODE_PICK, POS_FIRST, 8'd255, '1);
    send_item(MODE_PICK, POS_FIRST, 8'd254, 31'd0);
    send_item(MODE_PICK, POS_FIRST, 8'd1, '1);

    // Random: mostly well-formed sentences followed by picks, with some noise.
    while (sent < N_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom_range(1)), 2'($urandom_range(3)),
                  WORD_W'($urandom_range(255)), RAND_W'($urandom));
      end else begin
        w = pick_word();
        send_item(MODE_LEARN, POS_FIRST, w, RAND_W'($urandom));
        n = $urandom_range(5);
        repeat (n) begin
          w = pick_word();
          send_item(MODE_LEARN, $urandom_range(7) == 0 ? POS_RESERVED : POS_MIDDLE, w,
                    RAND_W'($urandom));
        end
        send_item(MODE_LEARN, POS_LAST, pick_word(), RAND_W'($urandom));
        repeat ($urandom_range(4)) begin
          w = ($urandom_range(3) == 0) ? START_SYM : pick_word();
          send_item(MODE_PICK, 2'($urandom_range(3)), w, RAND_W'($urandom));
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: bigram_count_and_roulette_pick_unit.f
sv/bcrp_pkg.sv
sv/bcrp_div.sv
sv/bigram_count_and_roulette_pick_unit.sv
sim/bigram_count_and_roulette_pick_unit_tb.sv
